// ----- design/tpcd_pkg.sv -----
package tpcd_pkg;

	// Fixed cursor geometry.
	localparam int unsigned CURSOR_SIDE = 16;
	localparam int unsigned SIDE_W      = 4;

	// Word positions within one cursor resource.
	localparam logic [5:0] HDR_WORDS     = 6'd2;
	localparam logic [5:0] PLANE_B_FIRST = 6'd18;
	localparam logic [5:0] LAST_WORD     = 6'd34;
	localparam logic [5:0] WORD_HOT_X    = 6'd0;
	localparam logic [5:0] WORD_HOT_Y    = 6'd1;

	// Centering marker and the hotspot it stands for.
	localparam logic [15:0] CENTER_MARK = 16'd256;
	localparam logic [15:0] CENTER_POS  = 16'd8;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREY  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 8'd2;

	// Reset values of the palette registers.
	localparam logic [7:0] WHITE_RST = 8'd15;
	localparam logic [7:0] GREY_RST  = 8'd7;
	localparam logic [7:0] TRANS_RST = 8'd1;
	localparam logic [7:0] BLACK_IDX = 8'd0;

	// Two-bit pixel code, first plane as the high bit.
	typedef enum logic [1:0] {
		CODE_BLACK = 2'd0,
		CODE_WHITE = 2'd1,
		CODE_TRANS = 2'd2,
		CODE_GREY  = 2'd3
	} pix_code_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic        start_flag;
	} word_t;

	typedef struct packed {
		logic [7:0]  pixel_color;
		logic [3:0]  pixel_x;
		logic [3:0]  pixel_y;
		logic [15:0] hotspot_x;
		logic [15:0] hotspot_y;
		logic        row_last;
		logic        image_last;
	} pixel_t;

	// Palette registers as seen by the pixel stage.
	typedef struct packed {
		logic [7:0] white_index;
		logic [7:0] grey_index;
		logic [7:0] transparent_index;
	} cfg_t;

	// One row job handed from the front to the back.
	typedef struct packed {
		logic [15:0] plane_a;
		logic [15:0] plane_b;
		logic [3:0]  row;
		logic [15:0] hot_x;
		logic [15:0] hot_y;
	} job_t;

endpackage

// ----- design/tpcd_front.sv -----
module tpcd_front import tpcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t in_data,
	input  logic  q_full,
	output logic  push,
	output job_t  push_job
);

	logic [5:0]  count_q;
	logic [15:0] hot_x_q;
	logic [15:0] hot_y_q;
	logic [15:0] rows_q [CURSOR_SIDE];

	logic        accept;
	logic [5:0]  idx;
	logic [3:0]  row;
	logic        is_plane_a;
	logic        is_plane_b;

	// A transaction is taken whenever the queue has room for a row job.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A start flag makes this word 0 whatever the count held.
	assign idx = in_data.start_flag ? 6'd0 : count_q;

	// First- and second-plane rows share the same low four bits of offset.
	assign row        = idx[3:0] - HDR_WORDS[3:0];
	assign is_plane_a = (idx >= HDR_WORDS) && (idx < PLANE_B_FIRST);
	assign is_plane_b = (idx >= PLANE_B_FIRST) && (idx < LAST_WORD);

	// Second-plane words become row jobs for the back.
	assign push              = accept && is_plane_b;
	assign push_job.plane_a  = rows_q[row];
	assign push_job.plane_b  = in_data.data_word;
	assign push_job.row      = row;
	assign push_job.hot_x    = hot_x_q;
	assign push_job.hot_y    = hot_y_q;

	// Word count and hotspot header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hot_x_q <= '0;
			hot_y_q <= '0;
		end else if (accept && (idx < LAST_WORD)) begin
			count_q <= idx + 6'd1;
			if (idx == WORD_HOT_X) begin
				hot_x_q <= in_data.data_word;
			end else if (idx == WORD_HOT_Y) begin
				if ((hot_x_q == 16'd0) && (in_data.data_word == CENTER_MARK)) begin
					hot_x_q <= CENTER_POS;
					hot_y_q <= CENTER_POS;
				end else begin
					hot_y_q <= in_data.data_word;
				end
			end
		end
	end

	// First-plane row store.
	always_ff @(posedge clk) begin
		if (accept && is_plane_a) begin
			rows_q[row] <= in_data.data_word;
		end
	end

endmodule

// ----- design/tpcd_queue.sv -----
module tpcd_queue import tpcd_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Job slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- design/tpcd_back.sv -----
module tpcd_back import tpcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  job_t   head_job,
	input  cfg_t   cfg,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output pixel_t out_data
);

	logic [SIDE_W-1:0] x_q;
	logic              out_valid_q;
	pixel_t            out_q;

	logic              advance;
	logic [SIDE_W-1:0] bit_sel;
	pix_code_t         code;
	logic [7:0]        color;
	logic              last_col;

	// A pixel moves into the output register when it is empty or being taken.
	assign advance  = head_valid && (!out_valid_q || out_ready);
	assign last_col = (x_q == SIDE_W'(CURSOR_SIDE - 1));
	assign pop      = advance && last_col;

	// Leftmost pixel is the most significant bit of the row.
	assign bit_sel = ~x_q;
	assign code    = pix_code_t'({head_job.plane_a[bit_sel], head_job.plane_b[bit_sel]});

	// Palette mapping of the pixel code.
	always_comb begin
		unique case (code)
			CODE_BLACK: color = BLACK_IDX;
			CODE_WHITE: color = cfg.white_index;
			CODE_TRANS: color = cfg.transparent_index;
			CODE_GREY:  color = cfg.grey_index;
			default:    color = BLACK_IDX;
		endcase
	end

	// Column counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			x_q         <= x_q + SIDE_W'(1);
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.pixel_color <= color;
			out_q.pixel_x     <= x_q;
			out_q.pixel_y     <= head_job.row;
			out_q.hotspot_x   <= head_job.hot_x;
			out_q.hotspot_y   <= head_job.hot_y;
			out_q.row_last    <= last_col;
			out_q.image_last  <= last_col && (head_job.row == SIDE_W'(CURSOR_SIDE - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/two_plane_cursor_decoder.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    word_t  (data_word, start_flag)
// out       output     out_valid / out_ready  pixel_t (one pixel per transaction)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data (palette registers)
//
// Header and first-plane words are absorbed and produce no output.
// Each second-plane word becomes a row job and yields 16 pixels, one per cycle while
// out_ready is held, so the single-pixel output stage sets the sustained input rate.
// Input is taken while the row-job queue (QUEUE_DEPTH entries) has room; output stalls
// back up into that queue and, when full, to the input. Reset clears the word count,
// hotspot, queue and the palette registers; the first-plane row store is not cleared.
module two_plane_cursor_decoder import tpcd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  word_t                in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pixel_t               out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	// Palette registers; indexes beyond the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.white_index       <= WHITE_RST;
			cfg_q.grey_index        <= GREY_RST;
			cfg_q.transparent_index <= TRANS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WHITE: cfg_q.white_index       <= cfg_data;
				REG_GREY:  cfg_q.grey_index        <= cfg_data;
				REG_TRANS: cfg_q.transparent_index <= cfg_data;
				default:   cfg_q                   <= cfg_q;
			endcase
		end
	end

	tpcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	tpcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	tpcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.cfg        (cfg_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ----- design/tpcd_checker.sv -----
module tpcd_checker import tpcd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input pixel_t               out_data
);

	// A stalled output transaction keeps its pixel.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output pixel changed while stalled");

	// Row end is flagged exactly on the rightmost column.
	a_row_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.row_last == (out_data.pixel_x == 4'hF)))
		else $error("row_last does not match the column");

	// Image end is the last pixel of the bottom row.
	a_image_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.image_last |-> out_data.row_last && (out_data.pixel_y == 4'hF))
		else $error("image_last off the bottom-right pixel");

	// Within a row the hotspot does not change between consecutive pixels.
	a_hot_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.row_last ##1 out_valid
		|-> $stable(out_data.hotspot_x) && $stable(out_data.hotspot_y))
		else $error("hotspot changed inside a row");

endmodule

bind two_plane_cursor_decoder tpcd_checker u_tpcd_checker (.*);
